FILE: rtl/core/ccr_pkg.sv
// ccr_pkg: types, constants and codes shared by the CAN chunk reassembler.
// Holds the input/result word structs, the per-node entry layout and the codes.
// No dependencies.
package ccr_pkg;

  localparam int NODE_COUNT_DEF = 16;
  localparam int STATUS_SHIFT   = 6;
  localparam int CHUNK_BYTES    = 8;
  localparam int ID_W           = 11;
  localparam int NODE_W         = ID_W - 2;  // full offset / 4, never truncated
  localparam int TIME_W         = 32;
  localparam int CFG_DATA_W     = 16;

  localparam logic [3:0] LEN_FULL   = 4'd8;
  localparam logic [3:0] FULL_MASK  = 4'hF;
  localparam logic [7:0] CONF_OK    = 8'd255;
  localparam logic [7:0] CONF_WARN  = 8'd128;
  localparam logic [7:0] CONF_NONE  = 8'd0;
  localparam logic [7:0] VALUE_MASK = 8'((1 << STATUS_SHIFT) - 1);

  localparam logic [ID_W-1:0] BASE_ID_RST  = 11'd256;
  localparam logic [ID_W-1:0] MOTOR_ID_RST = 11'd1152;
  localparam logic [15:0]     TIMEOUT_RST  = 16'd100;

  typedef enum logic [1:0] {
    OUT_DROP     = 2'd0,
    OUT_MOTOR    = 2'd1,
    OUT_STORED   = 2'd2,
    OUT_COMPLETE = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_WARN = 2'd1,
    ST_FAIL = 2'd2,
    ST_OFF  = 2'd3
  } sensor_status_t;

  typedef enum logic [1:0] {
    CFG_BASE_ID  = 2'd0,
    CFG_MOTOR_ID = 2'd1,
    CFG_TIMEOUT  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic            is_extended;
    logic            is_remote;
    logic [3:0]      length;
    logic [ID_W-1:0] frame_ident;
    logic [63:0]     payload;
    logic [31:0]     time_ms;
  } in_word_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [3:0]  node_index;
    logic [1:0]  chunk_index;
    logic [63:0] sensor_values;
    logic [15:0] sensor_statuses;
    logic [7:0]  valid_bits;
    logic [63:0] confidences;
    logic [31:0] completed_cycles;
    logic        assembly_restarted;
  } out_word_t;

  // Decode of one frame: kind is OUT_DROP, OUT_MOTOR or OUT_STORED (sensor chunk).
  typedef struct packed {
    outcome_t          kind;
    logic [NODE_W-1:0] node;
    logic [1:0]        chunk;
  } cls_t;

  typedef struct packed {
    logic [63:0] values;
    logic [15:0] statuses;
    logic [7:0]  valid;
    logic [63:0] confs;
  } sensor_t;

  // One node's assembly state as held in the state RAM.
  typedef struct packed {
    logic [3:0]        mask;
    logic [TIME_W-1:0] start;
    logic [31:0]       count;
  } node_entry_t;

endpackage

FILE: rtl/core/ccr_classify.sv
// ccr_classify: frame filter and id decode (node, chunk) for the reassembler.
// Depends on ccr_pkg.
module ccr_classify #(
  parameter int NODE_COUNT = ccr_pkg::NODE_COUNT_DEF
) (
  input  ccr_pkg::in_word_t              word,
  input  logic [ccr_pkg::ID_W-1:0]       base_id,
  input  logic [ccr_pkg::ID_W-1:0]       motor_id,
  output ccr_pkg::cls_t                  cls
);
  import ccr_pkg::*;

  logic [ID_W-1:0] rel;

  assign rel = word.frame_ident - base_id;

  always_comb begin
    cls.node  = rel[ID_W-1:2];
    cls.chunk = rel[1:0];
    if (word.is_extended || word.is_remote || (word.length != LEN_FULL)) begin
      cls.kind = OUT_DROP;
    end else if (word.frame_ident == motor_id) begin
      cls.kind = OUT_MOTOR;
    end else if (word.frame_ident < base_id) begin
      cls.kind = OUT_DROP;
    end else if (rel[ID_W-1:2] >= NODE_W'(NODE_COUNT)) begin
      cls.kind = OUT_DROP;
    end else begin
      cls.kind = OUT_STORED;
    end
  end

endmodule

FILE: rtl/core/ccr_sensor_unpack.sv
// ccr_sensor_unpack: splits eight payload bytes into value, status, valid, confidence.
// Depends on ccr_pkg.
module ccr_sensor_unpack (
  input  logic [63:0]      payload,
  output ccr_pkg::sensor_t sens
);
  import ccr_pkg::*;

  always_comb begin
    logic [7:0] raw;
    logic [1:0] st;
    sens = '0;
    for (int i = 0; i < CHUNK_BYTES; i++) begin
      raw = payload[8*i +: 8];
      st  = 2'(raw >> STATUS_SHIFT);
      sens.values[8*i +: 8] = raw & VALUE_MASK;
      sens.statuses[2*i +: 2] = st;
      sens.valid[i] = (st == ST_OK) || (st == ST_WARN);
      case (st)
        ST_OK:   sens.confs[8*i +: 8] = CONF_OK;
        ST_WARN: sens.confs[8*i +: 8] = CONF_WARN;
        default: sens.confs[8*i +: 8] = CONF_NONE;
      endcase
    end
  end

endmodule

FILE: rtl/core/ccr_state_ram.sv
// ccr_state_ram: per-node assembly state, one synchronous RAM with registered read.
// Per-entry valid flags give the all-zero reset; a same-cycle write is forwarded.
// Depends on ccr_pkg.
module ccr_state_ram #(
  parameter int NODE_COUNT = ccr_pkg::NODE_COUNT_DEF,
  parameter int ADDR_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output ccr_pkg::node_entry_t rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  ccr_pkg::node_entry_t wr_data
);
  import ccr_pkg::*;

  node_entry_t           mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] vld_r;
  logic [NODE_COUNT-1:0] vld_nxt;
  node_entry_t           rd_q_r;
  logic                  rd_vld_r;
  logic                  fwd_hit_r;
  node_entry_t           fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (rd_en) begin
        rd_vld_r  <= vld_r[rd_addr];
        // write landing on the entry being read this edge: take the new data
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      rd_data = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_data = rd_q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

FILE: rtl/core/can_chunk_reassembler_unit.sv
// can_chunk_reassembler_unit: CAN sensor chunk reassembler, top level.
// An accepted word passes the stage 1 registers, then the output register, to out_*.
// Throughput: one word per cycle unless out_stall holds; the state RAM reads at accept
//   and writes as stage 1 drains, separate ports, same cycle; same-node writes forwarded.
// Reset: rst_n synchronous low; config regs to defaults, node state reads as zero.
// Depends on ccr_pkg, ccr_classify, ccr_sensor_unpack, ccr_state_ram.
module can_chunk_reassembler_unit #(
  parameter int NODE_COUNT = ccr_pkg::NODE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ccr_pkg::in_word_t               in_word,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output ccr_pkg::out_word_t              out_word,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [ccr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ccr_pkg::*;

  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // ---------------- configuration registers ----------------
  logic [ID_W-1:0] base_id_r,  base_id_nxt;
  logic [ID_W-1:0] motor_id_r, motor_id_nxt;
  logic [15:0]     timeout_r,  timeout_nxt;

  always_comb begin
    base_id_nxt  = base_id_r;
    motor_id_nxt = motor_id_r;
    timeout_nxt  = timeout_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BASE_ID:  base_id_nxt  = cfg_data[ID_W-1:0];
        CFG_MOTOR_ID: motor_id_nxt = cfg_data[ID_W-1:0];
        CFG_TIMEOUT:  timeout_nxt  = cfg_data[15:0];
        default: ;  // unmapped index: no register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r  <= BASE_ID_RST;
      motor_id_r <= MOTOR_ID_RST;
      timeout_r  <= TIMEOUT_RST;
    end else begin
      base_id_r  <= base_id_nxt;
      motor_id_r <= motor_id_nxt;
      timeout_r  <= timeout_nxt;
    end
  end

  // ---------------- stage 0: classify, issue state read ----------------
  cls_t cls;
  logic in_acc;
  logic s1_adv;

  ccr_classify #(.NODE_COUNT(NODE_COUNT)) u_classify (
    .word     (in_word),
    .base_id  (base_id_r),
    .motor_id (motor_id_r),
    .cls      (cls)
  );

  assign in_acc = in_valid && !in_stall;

  // ---------------- stage 1 registers ----------------
  logic              s1_valid_r, s1_valid_nxt;
  outcome_t          s1_kind_r;
  logic [NODE_W-1:0] s1_node_r;
  logic [1:0]        s1_chunk_r;
  logic [63:0]       s1_payload_r;
  logic [TIME_W-1:0] s1_time_r;
  logic              out_valid_r, out_valid_nxt;

  // stage 1 drains whenever the output register is empty or being taken
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r    <= cls.kind;
      s1_node_r    <= cls.node;
      s1_chunk_r   <= cls.chunk;
      s1_payload_r <= in_word.payload;
      s1_time_r    <= in_word.time_ms;
    end
  end

  // ---------------- node state RAM ----------------
  node_entry_t ent;
  node_entry_t ent_nxt;
  logic        wr_en;

  assign wr_en = s1_valid_r && s1_adv && (s1_kind_r == OUT_STORED);

  ccr_state_ram #(.NODE_COUNT(NODE_COUNT), .ADDR_W(ADDR_W)) u_state_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc && (cls.kind == OUT_STORED)),
    .rd_addr (cls.node[ADDR_W-1:0]),
    .rd_data (ent),
    .wr_en   (wr_en),
    .wr_addr (s1_node_r[ADDR_W-1:0]),
    .wr_data (ent_nxt)
  );

  // ---------------- stage 1: modify ----------------
  sensor_t sens;

  ccr_sensor_unpack u_unpack (
    .payload (s1_payload_r),
    .sens    (sens)
  );

  logic              stale;
  logic              complete;
  logic [3:0]        mask_live;
  logic [3:0]        mask_marked;
  logic [TIME_W-1:0] age;

  always_comb begin
    age   = s1_time_r - ent.start;  // wraps modulo 2^32
    stale = (ent.mask != 4'd0) && (age > TIME_W'(timeout_r));
    // stale partial assembly is restarted
    mask_live   = stale ? 4'd0 : ent.mask;
    mask_marked = mask_live | (4'd1 << s1_chunk_r);
    complete    = (mask_marked == FULL_MASK);
    ent_nxt.mask  = complete ? 4'd0 : mask_marked;
    ent_nxt.start = (mask_live == 4'd0) ? s1_time_r : ent.start;
    ent_nxt.count = ent.count + 32'(complete);
  end

  // ---------------- output register ----------------
  out_word_t out_word_r,  out_word_nxt;

  always_comb begin
    out_word_nxt = '0;
    out_word_nxt.outcome = s1_kind_r;
    if (s1_kind_r == OUT_STORED) begin
      out_word_nxt.outcome            = complete ? OUT_COMPLETE : OUT_STORED;
      out_word_nxt.node_index         = s1_node_r[3:0];
      out_word_nxt.chunk_index        = s1_chunk_r;
      out_word_nxt.sensor_values      = sens.values;
      out_word_nxt.sensor_statuses    = sens.statuses;
      out_word_nxt.valid_bits         = sens.valid;
      out_word_nxt.confidences        = sens.confs;
      out_word_nxt.completed_cycles   = ent_nxt.count;
      out_word_nxt.assembly_restarted = stale;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---------------- assertions ----------------
  // state write-back only for an in-range node
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_node_r < NODE_W'(NODE_COUNT)))
    else $error("state write to out-of-range node");

  // a write-back always moves its word into the output register
  a_wr_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid_r)
    else $error("state written but no result word");

  // dropped and diverted words carry nothing but the outcome
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_word_r.outcome == OUT_DROP) ||
                     (out_word_r.outcome == OUT_MOTOR)))
    |-> ((out_word_r.completed_cycles == 32'd0) &&
         !out_word_r.assembly_restarted && (out_word_r.valid_bits == 8'd0)))
    else $error("non-sensor result word has payload");

  // input is only held off while stage 1 is occupied
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with free pipeline");

endmodule

FILE: tb/ccr_checker.sv
// ccr_checker: passive checker for can_chunk_reassembler_unit.
// Watches the input, result and register ports, predicts every result word and
// compares it field by field. Depends on ccr_pkg.
module ccr_checker #(
  parameter int NODE_COUNT = ccr_pkg::NODE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  ccr_pkg::in_word_t              in_word,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  ccr_pkg::out_word_t             out_word,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [ccr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             checked,
  output int                             completions,
  output int                             restarts
);
  import ccr_pkg::*;

  localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  logic [ID_W-1:0] base_id;
  logic [ID_W-1:0] motor_id;
  logic [15:0]     timeout_ms;

  logic [3:0]  seen_mask [NODE_COUNT];
  logic [31:0] asm_start [NODE_COUNT];
  logic [31:0] cycle_cnt [NODE_COUNT];

  out_word_t expected_q [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH word %0d %s: got %0h, expected %0h", checked, what, got, want);
    errors++;
  endtask

  // One frame through the reassembler: updates node state, returns the result word.
  task automatic predict_frame(input in_word_t f, output out_word_t r);
    logic [ID_W-1:0]   offset;
    logic [NODE_W-1:0] node;
    logic [IDX_W-1:0]  idx;
    logic [1:0]        chunk;
    logic [3:0]        mask;
    logic [31:0]       age;
    logic [7:0]        raw;
    sensor_status_t    st;
    r = '0;
    r.outcome = OUT_DROP;
    if (f.is_extended || f.is_remote || f.length != LEN_FULL) return;
    if (f.frame_ident == motor_id) begin
      r.outcome = OUT_MOTOR;
      return;
    end
    if (f.frame_ident < base_id) return;
    offset = f.frame_ident - base_id;
    node   = offset[ID_W-1:2];  // full width, no aliasing onto low nodes
    chunk  = offset[1:0];
    if (node >= NODE_W'(NODE_COUNT)) return;
    idx = node[IDX_W-1:0];

    mask = seen_mask[idx];
    age  = f.time_ms - asm_start[idx];
    if (mask != 4'd0 && age > {16'd0, timeout_ms}) begin
      mask = 4'd0;
      r.assembly_restarted = 1'b1;
    end
    if (mask == 4'd0) asm_start[idx] = f.time_ms;

    for (int i = 0; i < CHUNK_BYTES; i++) begin
      raw = f.payload[8*i +: 8];
      st  = sensor_status_t'(2'(raw >> STATUS_SHIFT));
      r.sensor_values[8*i +: 8]  = raw & VALUE_MASK;
      r.sensor_statuses[2*i +: 2] = st;
      case (st)
        ST_OK: begin
          r.valid_bits[i] = 1'b1;
          r.confidences[8*i +: 8] = CONF_OK;
        end
        ST_WARN: begin
          r.valid_bits[i] = 1'b1;
          r.confidences[8*i +: 8] = CONF_WARN;
        end
        default: r.confidences[8*i +: 8] = CONF_NONE;
      endcase
    end

    mask = mask | (4'd1 << chunk);
    if (mask == FULL_MASK) begin
      mask = 4'd0;
      cycle_cnt[idx] = cycle_cnt[idx] + 32'd1;
      r.outcome = OUT_COMPLETE;
    end else begin
      r.outcome = OUT_STORED;
    end
    seen_mask[idx]     = mask;
    r.node_index       = node[3:0];
    r.chunk_index      = chunk;
    r.completed_cycles = cycle_cnt[idx];
  endtask

  task automatic compare_result(input out_word_t got, input out_word_t want);
    if (got.outcome !== want.outcome)
      report_mismatch("outcome", 64'(got.outcome), 64'(want.outcome));
    if (got.node_index !== want.node_index)
      report_mismatch("node_index", 64'(got.node_index), 64'(want.node_index));
    if (got.chunk_index !== want.chunk_index)
      report_mismatch("chunk_index", 64'(got.chunk_index), 64'(want.chunk_index));
    if (got.sensor_values !== want.sensor_values)
      report_mismatch("sensor_values", got.sensor_values, want.sensor_values);
    if (got.sensor_statuses !== want.sensor_statuses)
      report_mismatch("sensor_statuses", 64'(got.sensor_statuses),
                      64'(want.sensor_statuses));
    if (got.valid_bits !== want.valid_bits)
      report_mismatch("valid_bits", 64'(got.valid_bits), 64'(want.valid_bits));
    if (got.confidences !== want.confidences)
      report_mismatch("confidences", got.confidences, want.confidences);
    if (got.completed_cycles !== want.completed_cycles)
      report_mismatch("completed_cycles", 64'(got.completed_cycles),
                      64'(want.completed_cycles));
    if (got.assembly_restarted !== want.assembly_restarted)
      report_mismatch("assembly_restarted", 64'(got.assembly_restarted),
                      64'(want.assembly_restarted));
  endtask

  // Everything sampled at the rising edge sees pre-edge values.
  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      base_id    = BASE_ID_RST;
      motor_id   = MOTOR_ID_RST;
      timeout_ms = TIMEOUT_RST;
      for (int n = 0; n < NODE_COUNT; n++) begin
        seen_mask[n] = 4'd0;
        asm_start[n] = 32'd0;
        cycle_cnt[n] = 32'd0;
      end
      expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BASE_ID:  base_id    = cfg_data[ID_W-1:0];
          CFG_MOTOR_ID: motor_id   = cfg_data[ID_W-1:0];
          CFG_TIMEOUT:  timeout_ms = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_frame(in_word, want);
        expected_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result word, outcome", 64'(out_word.outcome), 64'd0);
        end else begin
          want = expected_q.pop_front();
          compare_result(out_word, want);
          if (want.outcome == OUT_COMPLETE) completions++;
          if (want.assembly_restarted) restarts++;
        end
        checked++;
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: tb/tb.sv
// tb: top of the can_chunk_reassembler_unit testbench.
// Drives frame words and register writes, stalls the result side, runs the
// watchdog and prints the verdict. Depends on ccr_pkg, ccr_checker and the RTL.
module tb;
  import ccr_pkg::*;

  localparam int NODES          = NODE_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 4000;  // longest legal quiet stretch is the long hold
  localparam int LONG_HOLD      = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  logic                  cfg_wr_en = 1'b0;
  logic [1:0]            cfg_index = CFG_BASE_ID;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int errors, pending, checked, completions, restarts;

  // Register values as last written; used to aim frames at real nodes.
  logic [ID_W-1:0] cur_base    = BASE_ID_RST;
  logic [ID_W-1:0] cur_motor   = MOTOR_ID_RST;
  logic [15:0]     cur_timeout = TIMEOUT_RST;
  logic [31:0]     now_ms      = 32'd0;

  bit tx_quiet      = 1'b0;  // sender takes no gaps
  bit rx_quiet      = 1'b0;  // receiver takes no stalls
  bit long_hold_req = 1'b0;  // asks the receiver for one long stall
  int frames_sent   = 0;
  int settings_used = 1;
  int idle_cycles   = 0;

  always #6 clk = ~clk;

  can_chunk_reassembler_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ccr_checker #(.NODE_COUNT(NODES)) mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked),
    .completions (completions),
    .restarts    (restarts)
  );

  // Identifier of a given node/chunk under the current base; wraps past 2047,
  // which turns far nodes into below-base drops.
  function automatic logic [ID_W-1:0] chunk_id(input int node, input int chunk);
    return ID_W'(int'(cur_base) + 4 * node + chunk);
  endfunction

  // Well-formed standard data frame of length 8.
  function automatic in_word_t std_frame(input logic [ID_W-1:0] ident,
                                         input logic [63:0] data,
                                         input logic [31:0] stamp);
    in_word_t f;
    f             = '0;
    f.length      = LEN_FULL;
    f.frame_ident = ident;
    f.payload     = data;
    f.time_ms     = stamp;
    return f;
  endfunction

  // Offer one word after a random gap, hold it until accepted.
  task automatic send_frame(input in_word_t f);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= f;
    do @(posedge clk); while (in_stall);
    frames_sent++;
    // switch gap mode now and then so there are runs with no gaps at all
    if (frames_sent % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Stop offering and wait, sampling at the falling edge, until every result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [ID_W-1:0] base, input logic [ID_W-1:0] motor,
                            input logic [15:0] tmo);
    drain();
    write_reg(CFG_BASE_ID, CFG_DATA_W'(base));
    write_reg(CFG_MOTOR_ID, CFG_DATA_W'(motor));
    write_reg(CFG_TIMEOUT, tmo);
    cur_base    = base;
    cur_motor   = motor;
    cur_timeout = tmo;
    settings_used++;
  endtask

  // Mostly good sensor chunks aimed at a few hot nodes so assemblies complete;
  // the rest is motor status, below-base, out-of-range and malformed frames.
  task automatic send_random_frame();
    in_word_t    f;
    int          pick;
    int          node;
    int unsigned step;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0, 1, 2:  step = $urandom_range(0, 2 * int'(cur_timeout) + 2);
      3:        step = $urandom;
      default:  step = $urandom_range(0, 40);
    endcase
    now_ms = now_ms + step;
    f = std_frame(ID_W'(0), {$urandom, $urandom}, now_ms);
    if (pick < 75) begin
      node = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom_range(0, NODES - 1);
      f.frame_ident = chunk_id(node, $urandom_range(0, 3));
    end else if (pick < 80) begin
      f.frame_ident = cur_motor;
    end else if (pick < 85) begin
      f.frame_ident = (cur_base == '0) ? ID_W'($urandom)
                                       : ID_W'($urandom_range(0, int'(cur_base) - 1));
    end else if (pick < 90) begin
      f.frame_ident = chunk_id(NODES + $urandom_range(0, 511), $urandom_range(0, 3));
    end else begin
      f.is_extended = 1'($urandom_range(0, 1));
      f.is_remote   = 1'($urandom_range(0, 1));
      f.length      = 4'($urandom_range(0, 15));
      f.frame_ident = ($urandom_range(0, 1) == 1) ? chunk_id($urandom_range(0, 3), 0)
                                                  : ID_W'($urandom);
    end
    send_frame(f);
  endtask

  task automatic run_phase(input int items);
    repeat (items) send_random_frame();
  endtask

  // Result side: random stall before each word, plus one long hold on request
  // so the pipeline backs up into in_stall.
  initial begin : receiver
    int wait_n;
    int got;
    got = 0;
    forever begin
      wait_n = rx_quiet ? 0 : $urandom_range(0, 11);
      if (long_hold_req) begin
        wait_n        = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got++;
      if (got % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  // Ends a hung run: counts edges at which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("can_chunk_reassembler_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    in_word_t f;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset register values ---
    // node 0: zero payload at time 0, all-ones payload, then every status code in one payload
    send_frame(std_frame(chunk_id(0, 0), 64'h0, 32'd0));
    send_frame(std_frame(chunk_id(0, 1), '1, 32'd50));
    // age exactly at the timeout is not stale
    send_frame(std_frame(chunk_id(0, 2), 64'h0040_80C0_3F7F_BFFF, 32'd100));
    // repeated chunk leaves the mask alone
    send_frame(std_frame(chunk_id(0, 2), 64'hC080_4000_FFBF_7F3F, 32'd100));
    send_frame(std_frame(chunk_id(0, 3), {$urandom, $urandom}, 32'd100));  // completes
    send_frame(std_frame(chunk_id(0, 0), {$urandom, $urandom}, 32'd300));
    // one past the timeout: stale assembly restarted
    send_frame(std_frame(chunk_id(0, 1), {$urandom, $urandom}, 32'd401));

    // malformed frames
    f = std_frame(chunk_id(1, 0), {$urandom, $urandom}, 32'd500);
    f.is_extended = 1'b1;
    send_frame(f);
    f = std_frame(chunk_id(1, 0), {$urandom, $urandom}, 32'd500);
    f.is_remote = 1'b1;
    send_frame(f);
    f.is_remote = 1'b0;
    f.length = 4'd0;
    send_frame(f);
    f.length = 4'd15;
    send_frame(f);
    f.length = 4'd7;
    send_frame(f);
    f.length = 4'd9;
    send_frame(f);

    // motor status diverted; extended motor frame is still dropped
    send_frame(std_frame(MOTOR_ID_RST, {$urandom, $urandom}, 32'd600));
    f = std_frame(MOTOR_ID_RST, {$urandom, $urandom}, 32'd600);
    f.is_extended = 1'b1;
    send_frame(f);

    // below base, node just out of range (would alias node 0), highest id
    send_frame(std_frame(BASE_ID_RST - ID_W'(1), {$urandom, $urandom}, 32'd700));
    send_frame(std_frame(ID_W'(0), {$urandom, $urandom}, 32'd700));
    send_frame(std_frame(chunk_id(NODES, 0), {$urandom, $urandom}, 32'd700));
    send_frame(std_frame('1, {$urandom, $urandom}, 32'd700));

    // last node, timestamps wrapping through zero
    send_frame(std_frame(chunk_id(NODES - 1, 0), {$urandom, $urandom}, 32'hFFFF_FFF0));
    send_frame(std_frame(chunk_id(NODES - 1, 1), {$urandom, $urandom}, 32'hFFFF_FFFF));
    send_frame(std_frame(chunk_id(NODES - 1, 2), {$urandom, $urandom}, 32'h0000_0020));
    send_frame(std_frame(chunk_id(NODES - 1, 3), {$urandom, $urandom}, 32'h0000_0030));

    // --- random phases, each under its own register setting ---
    now_ms = $urandom;
    run_phase(250);

    // lowest base, highest motor id, zero timeout: any nonzero age restarts
    set_config(ID_W'(0), '1, 16'd0);
    now_ms = $urandom;
    run_phase(350);

    // highest base: only one id maps to a node; longest timeout
    set_config('1, ID_W'(0), 16'hFFFF);
    now_ms = $urandom;
    run_phase(200);

    // top of the id space, short timeout, clock about to wrap
    set_config(ID_W'(2048 - 4 * NODES), ID_W'(1000), 16'd20);
    now_ms = 32'hFFFF_FF00;
    run_phase(200);
    drain();  // sender pauses until every result is back
    run_phase(200);

    set_config(ID_W'($urandom), ID_W'($urandom), 16'($urandom_range(0, 300)));
    now_ms = $urandom;
    run_phase(350);

    // back to reset values, with one long result-side hold while the sender
    // keeps offering back to back so the block fills and stalls its input
    set_config(BASE_ID_RST, MOTOR_ID_RST, TIMEOUT_RST);
    now_ms = $urandom;
    run_phase(150);
    tx_quiet      = 1'b1;
    long_hold_req = 1'b1;
    run_phase(60);
    run_phase(150);

    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d frames under %0d register settings; %0d result words checked.",
             frames_sent, settings_used, checked);
    $display("Saw %0d node completions and %0d stale assemblies restarted.",
             completions, restarts);
    if (errors == 0 && pending == 0) begin
      $display("can_chunk_reassembler_unit test passed");
    end else begin
      $display("can_chunk_reassembler_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ccr_pkg.sv
rtl/core/ccr_classify.sv
rtl/core/ccr_sensor_unpack.sv
rtl/core/ccr_state_ram.sv
rtl/core/can_chunk_reassembler_unit.sv
tb/ccr_checker.sv
tb/tb.sv
